FILE: rtl/bhpq_pkg.sv
// Shared types and constants for the binary heap priority queue.
`timescale 1ns / 1ps
`default_nettype none

package bhpq_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int KEY_WIDTH_DEF = 32;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_POP_WAIT,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_PICK,
    S_DN_CMP,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/bhpq_if.sv
// Request and response channel interfaces of the heap queue.
`timescale 1ns / 1ps
`default_nettype none

interface bhpq_req_if #(
  parameter int KEY_WIDTH = 32
);
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [KEY_WIDTH-1:0] key;

  modport source (output valid, mode, key, input ready);
  modport sink   (input valid, mode, key, output ready);
endinterface

interface bhpq_rsp_if #(
  parameter int KEY_WIDTH = 32,
  parameter int CNT_W     = 7
);
  logic                 valid;
  logic                 ready;
  logic [KEY_WIDTH-1:0] top_key;
  logic [KEY_WIDTH-1:0] popped_key;
  logic [CNT_W-1:0]     entry_count;
  logic                 is_empty;
  logic [1:0]           status;

  modport source (output valid, top_key, popped_key, entry_count, is_empty, status,
                  input ready);
  modport sink   (input valid, top_key, popped_key, entry_count, is_empty, status,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/bhpq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module bhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bhpq_cmp.sv
// Shared ordering comparator: true when a orders strictly ahead of b.
`timescale 1ns / 1ps
`default_nettype none

module bhpq_cmp #(
  parameter int KEY_WIDTH = 32
) (
  input  wire logic                 max_first,
  input  wire logic [KEY_WIDTH-1:0] a,
  input  wire logic [KEY_WIDTH-1:0] b,
  output logic                      ahead
);

  always_comb begin
    if (max_first) begin
      ahead = (a > b);
    end else begin
      ahead = (a < b);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/binary_heap_priority_queue_unit.sv
// Top level of the binary heap priority queue: sift sequencer around one RAM.
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+---------------------------------------------
//   req     | in  | valid/ready   | mode, key
//   rsp     | out | valid/ready   | top_key, popped_key, entry_count, is_empty,
//           |     |               | status
//   wr_*    | in  | wr_en only    | wr_data = max_first
//
// One request at a time; ready is high only while the sequencer is idle.
// A refused request or a pop of the last entry goes straight to the result; a push reads
// and compares one parent per level raised, a pop reads the left and right child and
// compares per level lowered, skipping the right read where a node has only a left child.
// Reset (rst, synchronous) empties the queue, clears max_first.
// A waiting result holds the sequencer in its final state only if a second would collide.
`timescale 1ns / 1ps
`default_nettype none

module binary_heap_priority_queue_unit
  import bhpq_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF,
  localparam int ADDR_W   = $clog2(CAPACITY),
  localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  wire logic clk,
  input  wire logic rst,
  bhpq_req_if.sink  req,
  bhpq_rsp_if.source rsp,
  input  wire logic wr_en,
  input  wire logic wr_data
);

  localparam int EXT_W = ADDR_W + 2;

  state_t               state, state_next;
  logic [ADDR_W-1:0]    pos, pos_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [KEY_WIDTH-1:0] moving, moving_next;
  logic [KEY_WIDTH-1:0] best, best_next;
  logic [ADDR_W-1:0]    best_idx, best_idx_next;
  logic [KEY_WIDTH-1:0] popped, popped_next;
  status_t              stat, stat_next;
  logic [KEY_WIDTH-1:0] root;
  logic                 max_first;

  logic                 rsp_valid, rsp_valid_next;
  logic [KEY_WIDTH-1:0] rsp_top, rsp_popped;
  logic [CNT_W-1:0]     rsp_count;
  logic                 rsp_empty;
  status_t              rsp_status;
  logic                 rsp_load;

  logic                 ram_we, ram_re;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [KEY_WIDTH-1:0] ram_wdata, ram_rdata;

  logic [KEY_WIDTH-1:0] cmp_a, cmp_b;
  logic                 cmp_before;

  logic [EXT_W-1:0]     child_ext, child1_ext, count_ext;
  logic [ADDR_W-1:0]    parent;

  bhpq_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  bhpq_cmp #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_cmp (
    .max_first (max_first),
    .a         (cmp_a),
    .b         (cmp_b),
    .ahead     (cmp_before)
  );

  assign child_ext  = EXT_W'({pos, 1'b1});
  assign child1_ext = child_ext + EXT_W'(1);
  assign count_ext  = EXT_W'(count);
  assign parent     = (pos - ADDR_W'(1)) >> 1;

  // The comparator serves three compares: moving vs parent, right vs left
  // child, moving vs chosen child.
  always_comb begin
    case (state)
      S_DN_PICK: begin
        cmp_a = ram_rdata;
        cmp_b = best;
      end
      S_DN_CMP: begin
        cmp_a = moving;
        cmp_b = best;
      end
      default: begin
        cmp_a = moving;
        cmp_b = ram_rdata;
      end
    endcase
  end

  assign req.ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    pos_next      = pos;
    count_next    = count;
    moving_next   = moving;
    best_next     = best;
    best_idx_next = best_idx;
    popped_next   = popped;
    stat_next     = stat;
    ram_we        = 1'b0;
    ram_waddr     = pos;
    ram_wdata     = moving;
    ram_re        = 1'b0;
    ram_raddr     = pos;
    rsp_load      = 1'b0;

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          popped_next = '0;
          stat_next   = ST_OK;
          if (req.mode == MODE_PUSH) begin
            if (count >= CNT_W'(CAPACITY)) begin
              stat_next  = ST_FULL;
              state_next = S_DONE;
            end else begin
              pos_next    = count[ADDR_W-1:0];
              moving_next = req.key;
              count_next  = count + CNT_W'(1);
              state_next  = S_UP_RD;
            end
          end else begin
            if (count == '0) begin
              stat_next  = ST_EMPTY;
              state_next = S_DONE;
            end else begin
              popped_next = root;
              count_next  = count - CNT_W'(1);
              if (count == CNT_W'(1)) begin
                state_next = S_DONE;
              end else begin
                // fetch the last entry; it becomes the moving entry
                ram_re     = 1'b1;
                ram_raddr  = ADDR_W'(count - CNT_W'(1));
                state_next = S_POP_WAIT;
              end
            end
          end
        end
      end

      S_UP_RD: begin
        if (pos == '0) begin
          ram_we     = 1'b1;
          state_next = S_DONE;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = parent;
          state_next = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        ram_we = 1'b1;
        if (cmp_before) begin
          // move the parent down into the hole
          ram_wdata  = ram_rdata;
          pos_next   = parent;
          state_next = S_UP_RD;
        end else begin
          state_next = S_DONE;
        end
      end

      S_POP_WAIT: begin
        moving_next = ram_rdata;
        pos_next    = '0;
        state_next  = S_DN_RDL;
      end

      S_DN_RDL: begin
        if (child_ext >= count_ext) begin
          ram_we     = 1'b1;
          state_next = S_DONE;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = child_ext[ADDR_W-1:0];
          state_next = S_DN_RDR;
        end
      end

      S_DN_RDR: begin
        best_next     = ram_rdata;
        best_idx_next = child_ext[ADDR_W-1:0];
        if (child1_ext < count_ext) begin
          ram_re     = 1'b1;
          ram_raddr  = child1_ext[ADDR_W-1:0];
          state_next = S_DN_PICK;
        end else begin
          state_next = S_DN_CMP;
        end
      end

      S_DN_PICK: begin
        // left child wins a tie
        if (cmp_before) begin
          best_next     = ram_rdata;
          best_idx_next = child1_ext[ADDR_W-1:0];
        end
        state_next = S_DN_CMP;
      end

      S_DN_CMP: begin
        ram_we = 1'b1;
        if (cmp_before) begin
          state_next = S_DONE;
        end else begin
          ram_wdata  = best;
          pos_next   = best_idx;
          state_next = S_DN_RDL;
        end
      end

      S_DONE: begin
        // hold until the output register is free
        if (!rsp_valid || rsp.ready) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (rsp_load) begin
      rsp_valid_next = 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      moving    <= '0;
      stat      <= ST_OK;
      rsp_valid <= 1'b0;
      max_first <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      moving    <= moving_next;
      stat      <= stat_next;
      rsp_valid <= rsp_valid_next;
      if (wr_en) begin
        max_first <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    best     <= best_next;
    best_idx <= best_idx_next;
    popped   <= popped_next;
    // mirror of entry zero so the top is known without a read
    if (ram_we && ram_waddr == '0) begin
      root <= ram_wdata;
    end
    if (rsp_load) begin
      rsp_top    <= (count != '0) ? root : '0;
      rsp_popped <= popped;
      rsp_count  <= count;
      rsp_empty  <= (count == '0);
      rsp_status <= stat;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.top_key     = rsp_top;
  assign rsp.popped_key  = rsp_popped;
  assign rsp.entry_count = rsp_count;
  assign rsp.is_empty    = rsp_empty;
  assign rsp.status      = rsp_status;

endmodule

`default_nettype wire

FILE: rtl/bhpq_checker.sv
// Port-level checks for the heap queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bhpq_checker
  import bhpq_pkg::*;
#(
  parameter int KEY_WIDTH = 32,
  parameter int CNT_W     = 7
) (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 req_valid,
  input wire logic                 req_ready,
  input wire logic                 rsp_valid,
  input wire logic                 rsp_ready,
  input wire logic [KEY_WIDTH-1:0] top_key,
  input wire logic [KEY_WIDTH-1:0] popped_key,
  input wire logic [CNT_W-1:0]     entry_count,
  input wire logic                 is_empty,
  input wire logic [1:0]           status
);

  // a stalled response holds its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(top_key) && $stable(popped_key)
      && $stable(entry_count) && $stable(status))
    else $error("response dropped or changed while stalled");

  // one request at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while a request is in progress");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (is_empty == (entry_count == '0)))
    else $error("is_empty disagrees with entry_count");

  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && is_empty |-> top_key == '0)
    else $error("nonzero top key on an empty queue");

  a_refused: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> popped_key == '0)
    else $error("refused request reports a popped key");

endmodule

bind binary_heap_priority_queue_unit bhpq_checker #(
  .KEY_WIDTH (KEY_WIDTH),
  .CNT_W     (CNT_W)
) u_bhpq_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .top_key     (rsp.top_key),
  .popped_key  (rsp.popped_key),
  .entry_count (rsp.entry_count),
  .is_empty    (rsp.is_empty),
  .status      (rsp.status)
);

`default_nettype wire

FILE: bench/binary_heap_priority_queue_unit_tb.sv
// Self-checking testbench for the binary heap priority queue unit.
`timescale 1ns / 1ps

module binary_heap_priority_queue_unit_tb;
  import bhpq_pkg::*;

  localparam int HEAP_DEPTH = CAPACITY_DEF;
  localparam int KEY_W      = KEY_WIDTH_DEF;
  localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);

  typedef struct {
    logic [KEY_W-1:0] top_key;
    logic [KEY_W-1:0] popped_key;
    logic [CNT_W-1:0] entry_count;
    logic             is_empty;
    status_t          status;
  } heap_result_t;

  logic clk;
  logic rst;
  logic wr_en;
  logic wr_data;

  bhpq_req_if #(.KEY_WIDTH(KEY_W))                req_bus ();
  bhpq_rsp_if #(.KEY_WIDTH(KEY_W), .CNT_W(CNT_W)) rsp_bus ();

  binary_heap_priority_queue_unit uut (
    .clk    (clk),
    .rst    (rst),
    .req    (req_bus),
    .rsp    (rsp_bus),
    .wr_en  (wr_en),
    .wr_data(wr_data)
  );

  // Shadow heap and the results it predicts, oldest first.
  logic [KEY_W-1:0] heap_shadow [HEAP_DEPTH];
  int               heap_fill;
  bit               order_max;
  heap_result_t     pending_results[$];
  int               failures;
  bit               steady;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic bit orders_ahead(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
    return order_max ? (a > b) : (a < b);
  endfunction

  function automatic void predict_request(logic mode, logic [KEY_W-1:0] key);
    heap_result_t     r;
    int               pos;
    int               parent;
    int               child;
    logic [KEY_W-1:0] moving;
    r.popped_key = '0;
    r.status     = ST_OK;
    if (mode == MODE_PUSH) begin
      if (heap_fill >= HEAP_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = heap_fill;
        heap_fill++;
        moving = key;
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (!orders_ahead(moving, heap_shadow[parent])) break;
          heap_shadow[pos] = heap_shadow[parent];
          pos = parent;
        end
        heap_shadow[pos] = moving;
      end
    end else if (heap_fill == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.popped_key = heap_shadow[0];
      heap_fill--;
      heap_shadow[0] = heap_shadow[heap_fill];
      if (heap_fill > 0) begin
        pos = 0;
        moving = heap_shadow[0];
        while (2 * pos + 1 < heap_fill) begin
          child = 2 * pos + 1;
          // left child wins a tie
          if (child + 1 < heap_fill && orders_ahead(heap_shadow[child + 1], heap_shadow[child]))
            child++;
          if (orders_ahead(moving, heap_shadow[child])) break;
          heap_shadow[pos] = heap_shadow[child];
          pos = child;
        end
        heap_shadow[pos] = moving;
      end
    end
    r.top_key     = (heap_fill > 0) ? heap_shadow[0] : '0;
    r.entry_count = CNT_W'(heap_fill);
    r.is_empty    = (heap_fill == 0);
    pending_results.push_back(r);
  endfunction

  // Drive the response side: stall at random unless in a steady stretch.
  initial begin
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_bus.ready <= steady || ($urandom_range(99) >= 18);
    end
  end

  always @(posedge clk) begin
    heap_result_t e;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: top_key %0h entry_count %0d", rsp_bus.top_key,
               rsp_bus.entry_count);
        failures++;
      end else begin
        e = pending_results.pop_front();
        if (rsp_bus.top_key !== e.top_key) begin
          $error("top_key expected %0h got %0h", e.top_key, rsp_bus.top_key);
          failures++;
        end
        if (rsp_bus.popped_key !== e.popped_key) begin
          $error("popped_key expected %0h got %0h", e.popped_key, rsp_bus.popped_key);
          failures++;
        end
        if (rsp_bus.entry_count !== e.entry_count) begin
          $error("entry_count expected %0d got %0d", e.entry_count, rsp_bus.entry_count);
          failures++;
        end
        if (rsp_bus.is_empty !== e.is_empty) begin
          $error("is_empty expected %0b got %0b", e.is_empty, rsp_bus.is_empty);
          failures++;
        end
        if (rsp_bus.status !== e.status) begin
          $error("status expected %0d got %0d", e.status, rsp_bus.status);
          failures++;
        end
      end
    end
  end

  // Keep valid high across back-to-back requests; drop it only for a gap.
  task automatic send_request(logic mode, logic [KEY_W-1:0] key);
    if (!steady && $urandom_range(99) < 18) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.mode  <= mode;
    req_bus.key   <= key;
    do @(posedge clk); while (!req_bus.ready);
    predict_request(mode, key);
  endtask

  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_order(bit largest_first);
    wait_drained();
    wr_en   <= 1'b1;
    wr_data <= largest_first;
    @(posedge clk);
    wr_en <= 1'b0;
    order_max = largest_first;
    @(posedge clk);
  endtask

  task automatic test_empty_and_single();
    send_request(MODE_POP, 32'hFFFF_FFFF);
    send_request(MODE_PUSH, 32'hFFFF_FFFF);
    send_request(MODE_POP, 32'h0);
    send_request(MODE_POP, 32'h0);
  endtask

  task automatic test_key_extremes();
    send_request(MODE_PUSH, 32'h8000_0000);
    send_request(MODE_PUSH, 32'hFFFF_FFFF);
    send_request(MODE_PUSH, 32'h0000_0000);
    send_request(MODE_PUSH, 32'h7FFF_FFFF);
    send_request(MODE_PUSH, 32'h5555_5555);
    send_request(MODE_PUSH, 32'hAAAA_AAAA);
    send_request(MODE_PUSH, 32'h0000_0000);
    send_request(MODE_PUSH, 32'h0000_0001);
    repeat (8) send_request(MODE_POP, $urandom);
  endtask

  // Switch order with entries held: they stay where they are.
  task automatic test_largest_first();
    write_order(1'b1);
    send_request(MODE_PUSH, 32'h0000_0010);
    send_request(MODE_PUSH, 32'hFFFF_FFFF);
    send_request(MODE_PUSH, 32'h0000_0010);
    send_request(MODE_PUSH, 32'h0000_0003);
    send_request(MODE_POP, 32'h0);
    write_order(1'b0);
    repeat (4) send_request(MODE_POP, 32'h0);
  endtask

  task automatic test_full_heap();
    repeat (HEAP_DEPTH) send_request(MODE_PUSH, $urandom);
    send_request(MODE_PUSH, $urandom);
    repeat (HEAP_DEPTH + 1) send_request(MODE_POP, $urandom);
  endtask

  function automatic logic [KEY_W-1:0] pick_key(int style);
    case (style)
      0:       return $urandom;
      1:       return $urandom_range(15);
      default: begin
        case ($urandom_range(3))
          0:       return $urandom_range(3);
          1:       return 32'hFFFF_FFFF - $urandom_range(3);
          2:       return 32'h8000_0000 ^ $urandom_range(1);
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // Phases of push-heavy, balanced and pop-heavy traffic under both orders.
  task automatic test_random_traffic(int total);
    int   sent;
    int   phase;
    int   span;
    int   push_pct;
    int   key_style;
    logic mode;
    sent  = 0;
    phase = 0;
    while (sent < total) begin
      write_order($urandom_range(1));
      steady = (phase == 4);
      span = $urandom_range(40, 120);
      case ($urandom_range(2))
        0:       push_pct = 35;
        1:       push_pct = 55;
        default: push_pct = 75;
      endcase
      key_style = $urandom_range(2);
      repeat (span) begin
        mode = ($urandom_range(99) < push_pct) ? MODE_PUSH : MODE_POP;
        send_request(mode, pick_key(key_style));
        sent++;
      end
      phase++;
    end
    steady = 1'b0;
  endtask

  initial begin
    failures  = 0;
    heap_fill = 0;
    order_max = 1'b0;
    steady    = 1'b0;
    rst           <= 1'b1;
    wr_en         <= 1'b0;
    wr_data       <= 1'b0;
    req_bus.valid <= 1'b0;
    req_bus.mode  <= MODE_PUSH;
    req_bus.key   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_and_single();
    test_key_extremes();
    test_largest_first();
    test_full_heap();
    test_random_traffic(1100);

    wait_drained();
    repeat (40) @(posedge clk);
    if (failures == 0) begin
      $display("binary_heap_priority_queue_unit: match");
    end else begin
      $display("binary_heap_priority_queue_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("binary_heap_priority_queue_unit: mismatch");
    $finish;
  end

endmodule
